// File: rtl/wfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_pkg
// Shared constants and types for the websocket frame decoder.
// ----------------------------------------------------------------------------
package wfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned LenW  = 64;
  localparam int unsigned KeyW  = 32;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [KindW-1:0] KIND_TEXT  = 2'd0;
  localparam logic [KindW-1:0] KIND_PING  = 2'd1;
  localparam logic [KindW-1:0] KIND_CLOSE = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic             has_data;
    logic [ByteW-1:0] data;
    logic             last;
  } wfd_result_t;

endpackage

// File: rtl/websocket_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Byte-stream websocket frame parser: text and ping payload out, close event.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and yields at most one result per byte:
// unmasked text or ping payload bytes, an empty-message marker, or a close
// event, after which input is swallowed until reset. Sustained rate is one
// byte per cycle while the result stream is not stalled; a byte goes through
// an input register, one pass of the header/payload parser, and the result
// register. The parser advances only when the result register is free or
// being drained; while a result waits, a byte held in the input register
// stays there and s_axis_tready is low in that same cycle.
module websocket_frame_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [wfd_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] in_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [wfd_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]                 m_axis_tuser,   // [1:0] kind, [2] has_data
  output logic                       m_axis_tlast    // last
);
  import wfd_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [ByteW-1:0]  in_byte_q;
  logic              consume;
  logic              out_full;
  logic [KindW-1:0]  out_kind;
  logic              out_has_data;
  wfd_result_t       res;

  assign consume       = in_valid_q && !out_full;
  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (consume),
    .byte_i    (in_byte_q),
    .res_o     (res)
  );

  wfd_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (consume),
    .res_i         (res),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .data_o        (m_axis_tdata),
    .kind_o        (out_kind),
    .has_data_o    (out_has_data),
    .last_o        (m_axis_tlast),
    .full_o        (out_full)
  );

  assign m_axis_tuser = {out_has_data, out_kind};

endmodule

// File: rtl/wfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_parser
// Frame header parser and payload unmasker; one byte per consume cycle.
// ----------------------------------------------------------------------------
module wfd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       consume_i,
  input  logic [wfd_pkg::ByteW-1:0]  byte_i,
  output wfd_pkg::wfd_result_t       res_o
);
  import wfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [3:0]        opcode_q, opcode_d;
  logic              mask_on_q, mask_on_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [2:0]        ext_cnt_q, ext_cnt_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [1:0]        key_idx_q, key_idx_d;

  logic              len_done;
  logic              hdr_done;
  logic              pl_last;
  logic [ByteW-1:0]  key_byte;
  logic [ByteW-1:0]  pl_byte;
  logic [6:0]        len_code;
  wfd_result_t       res;

  assign len_code = byte_i[6:0];
  assign pl_last  = (len_q == LenW'(1));

  always_comb begin
    case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign pl_byte = mask_on_q ? (byte_i ^ key_byte) : byte_i;

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    mask_on_d = mask_on_q;
    len_d     = len_q;
    ext_cnt_d = ext_cnt_q;
    key_d     = key_q;
    key_idx_d = key_idx_q;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    res       = '0;

    if (consume_i) begin
      case (phase_q)
        PH_HDR1: begin
          opcode_d = byte_i[3:0];
          phase_d  = PH_HDR2;
        end
        PH_HDR2: begin
          mask_on_d = byte_i[7];
          len_d     = '0;
          if (len_code == LEN_CODE_EXT16) begin
            ext_cnt_d = 3'd1;
            phase_d   = PH_EXTLEN;
          end else if (len_code == LEN_CODE_EXT64) begin
            ext_cnt_d = 3'd7;
            phase_d   = PH_EXTLEN;
          end else begin
            len_d    = LenW'(len_code);
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_d = {len_q[LenW-ByteW-1:0], byte_i};
          if (ext_cnt_q == 3'd0) begin
            len_done = 1'b1;
          end else begin
            ext_cnt_d = ext_cnt_q - 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[KeyW-ByteW-1:0], byte_i};
          if (key_idx_q == 2'd3) begin
            hdr_done = 1'b1;
          end else begin
            key_idx_d = key_idx_q + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          key_idx_d = key_idx_q + 2'd1;
          len_d     = len_q - LenW'(1);
          if (opcode_q == OP_CLOSE) begin
            if (pl_last) begin
              phase_d   = PH_CLOSED;
              res.valid = 1'b1;
              res.kind  = KIND_CLOSE;
              res.last  = 1'b1;
            end
          end else begin
            if (pl_last) begin
              phase_d = PH_HDR1;
            end
            if (opcode_q == OP_TEXT || opcode_q == OP_PING) begin
              res.valid    = 1'b1;
              res.kind     = (opcode_q == OP_TEXT) ? KIND_TEXT : KIND_PING;
              res.has_data = 1'b1;
              res.data     = pl_byte;
              res.last     = pl_last;
            end
          end
        end
        PH_CLOSED: begin
          phase_d = PH_CLOSED;
        end
        default: begin
          phase_d = PH_CLOSED;
        end
      endcase

      if (len_done) begin
        if (mask_on_d) begin
          phase_d   = PH_MASK;
          key_idx_d = 2'd0;
          key_d     = '0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        key_idx_d = 2'd0;
        if (len_d == '0) begin
          res.last = 1'b1;
          if (opcode_q == OP_CLOSE) begin
            phase_d   = PH_CLOSED;
            res.valid = 1'b1;
            res.kind  = KIND_CLOSE;
          end else begin
            phase_d = PH_HDR1;
            if (opcode_q == OP_TEXT || opcode_q == OP_PING) begin
              res.valid = 1'b1;
              res.kind  = (opcode_q == OP_TEXT) ? KIND_TEXT : KIND_PING;
            end
          end
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR1;
      opcode_q  <= '0;
      mask_on_q <= 1'b0;
      len_q     <= '0;
      ext_cnt_q <= '0;
      key_q     <= '0;
      key_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_on_q <= mask_on_d;
      len_q     <= len_d;
      ext_cnt_q <= ext_cnt_d;
      key_q     <= key_d;
      key_idx_q <= key_idx_d;
    end
  end

  assign res_o = res;

endmodule

// File: rtl/wfd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module wfd_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  wfd_pkg::wfd_result_t       res_i,
  input  logic                       m_axis_tready,
  output logic                       m_axis_tvalid,
  output logic [wfd_pkg::ByteW-1:0]  data_o,
  output logic [wfd_pkg::KindW-1:0]  kind_o,
  output logic                       has_data_o,
  output logic                       last_o,
  output logic                       full_o
);
  import wfd_pkg::*;

  logic        valid_q, valid_d;
  wfd_result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i && res_i.valid) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign data_o        = res_q.data;
  assign kind_o        = res_q.kind;
  assign has_data_o    = res_q.has_data;
  assign last_o        = res_q.last;
  assign full_o        = valid_q && !m_axis_tready;

endmodule

// File: rtl/wfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_checker
// Port-level checks on the decoder's input and result streams.
// ----------------------------------------------------------------------------
module wfd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [wfd_pkg::ByteW-1:0]  s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [wfd_pkg::ByteW-1:0]  m_axis_tdata,
  input logic [2:0]                 m_axis_tuser,
  input logic                       m_axis_tlast
);
  import wfd_pkg::*;

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
    else $error("accepted input beat carries unknown data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] == KIND_TEXT || m_axis_tuser[1:0] == KIND_PING
                       || m_axis_tuser[1:0] == KIND_CLOSE))
    else $error("illegal result kind");

  a_close_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_CLOSE |->
      m_axis_tlast && !m_axis_tuser[2] && m_axis_tdata == '0)
    else $error("close event malformed");

  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("empty marker malformed");

endmodule

bind websocket_frame_decoder wfd_checker u_wfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: test/websocket_frame_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder_checker
// Watches both streams of the frame decoder, predicts its output beats and
// compares each accepted output beat field by field with the oldest one due.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_checker
  import wfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [ByteW-1:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [ByteW-1:0]  m_axis_tdata_i,   // [7:0] out_byte
  input  logic [2:0]        m_axis_tuser_i,   // [1:0] kind, [2] has_data
  input  logic              m_axis_tlast_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_count_o
);

  typedef enum logic [2:0] {
    ST_OPCODE,
    ST_LEN7,
    ST_EXT_LEN,
    ST_KEY,
    ST_BODY,
    ST_SHUT
  } parse_state_e;

  localparam int unsigned DueDepth = 16;

  parse_state_e      st       = ST_OPCODE;
  logic [3:0]        op       = '0;
  logic              masked   = 1'b0;
  logic [LenW-1:0]   left     = '0;
  logic [2:0]        ext_left = '0;
  logic [KeyW-1:0]   key      = '0;
  logic [1:0]        key_idx  = '0;

  wfd_result_t       due_ring[DueDepth];
  int unsigned       due_wr    = 0;
  int unsigned       due_rd    = 0;
  int unsigned       due_count = 0;
  int unsigned       mismatches = 0;

  function automatic wfd_result_t result_beat(input logic [KindW-1:0] kind,
                                              input logic has_data,
                                              input logic [ByteW-1:0] data,
                                              input logic last);
    wfd_result_t r;
    r.valid    = 1'b1;
    r.kind     = kind;
    r.has_data = has_data;
    r.data     = data;
    r.last     = last;
    return r;
  endfunction

  // header complete: empty frames report right here
  function automatic wfd_result_t finish_header();
    wfd_result_t r;
    r       = '0;
    key_idx = '0;
    if (left != '0) begin
      st = ST_BODY;
    end else if (op == OP_CLOSE) begin
      st = ST_SHUT;
      r  = result_beat(KIND_CLOSE, 1'b0, '0, 1'b1);
    end else begin
      st = ST_OPCODE;
      if (op == OP_TEXT) begin
        r = result_beat(KIND_TEXT, 1'b0, '0, 1'b1);
      end else if (op == OP_PING) begin
        r = result_beat(KIND_PING, 1'b0, '0, 1'b1);
      end
    end
    return r;
  endfunction

  function automatic wfd_result_t finish_length();
    if (masked) begin
      st      = ST_KEY;
      key_idx = '0;
      key     = '0;
      return '0;
    end
    return finish_header();
  endfunction

  function automatic wfd_result_t decode_byte(input logic [ByteW-1:0] b);
    wfd_result_t r;
    logic [ByteW-1:0] v;
    r = '0;
    case (st)
      ST_OPCODE: begin
        op = b[3:0];
        st = ST_LEN7;
      end
      ST_LEN7: begin
        masked = b[7];
        left   = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          ext_left = 3'd1;
          st       = ST_EXT_LEN;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          ext_left = 3'd7;
          st       = ST_EXT_LEN;
        end else begin
          left = LenW'(b[6:0]);
          r    = finish_length();
        end
      end
      ST_EXT_LEN: begin
        left = {left[LenW-9:0], b};
        if (ext_left == '0) begin
          r = finish_length();
        end else begin
          ext_left = ext_left - 3'd1;
        end
      end
      ST_KEY: begin
        key = {key[KeyW-9:0], b};
        if (key_idx == 2'd3) begin
          r = finish_header();
        end else begin
          key_idx = key_idx + 2'd1;
        end
      end
      ST_BODY: begin
        // key byte index counts from the top byte of the key
        v = masked ? (b ^ ByteW'(key >> {~key_idx, 3'b000})) : b;
        key_idx = key_idx + 2'd1;
        left    = left - LenW'(1);
        if (op == OP_CLOSE) begin
          if (left == '0) begin
            st = ST_SHUT;
            r  = result_beat(KIND_CLOSE, 1'b0, '0, 1'b1);
          end
        end else begin
          if (left == '0) begin
            st = ST_OPCODE;
          end
          if (op == OP_TEXT) begin
            r = result_beat(KIND_TEXT, 1'b1, v, left == '0);
          end else if (op == OP_PING) begin
            r = result_beat(KIND_PING, 1'b1, v, left == '0);
          end
        end
      end
      default: begin
        st = ST_SHUT;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    wfd_result_t want;
    wfd_result_t fresh;
    if (!rst_ni) begin
      st       = ST_OPCODE;
      op       = '0;
      masked   = 1'b0;
      left     = '0;
      ext_left = '0;
      key      = '0;
      key_idx  = '0;
      due_wr    = 0;
      due_rd    = 0;
      due_count = 0;
      pending_count_o  <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      // outputs first: a beat leaving now never stems from the byte taken now
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_count == 0) begin
          mismatches++;
          $error("output beat with nothing due: kind %0d has_data %0d out_byte 0x%02h",
                 m_axis_tuser_i[1:0], m_axis_tuser_i[2], m_axis_tdata_i);
        end else begin
          want      = due_ring[due_rd];
          due_rd    = (due_rd + 1) % DueDepth;
          due_count = due_count - 1;
          if (m_axis_tuser_i[1:0] !== want.kind) begin
            mismatches++;
            $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser_i[1:0]);
          end
          if (m_axis_tuser_i[2] !== want.has_data) begin
            mismatches++;
            $error("has_data: expected %0d, actual %0d", want.has_data, m_axis_tuser_i[2]);
          end
          if (m_axis_tdata_i !== want.data) begin
            mismatches++;
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, m_axis_tdata_i);
          end
          if (m_axis_tlast_i !== want.last) begin
            mismatches++;
            $error("last: expected %0d, actual %0d", want.last, m_axis_tlast_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        fresh = decode_byte(s_axis_tdata_i);
        if (fresh.valid) begin
          if (due_count == DueDepth) begin
            mismatches++;
            $error("pending: expected below %0d, actual %0d", DueDepth, due_count);
          end else begin
            due_ring[due_wr] = fresh;
            due_wr    = (due_wr + 1) % DueDepth;
            due_count = due_count + 1;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= due_count;
    end
  end

endmodule

// File: test/websocket_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder_tb
// Feeds the frame decoder a byte stream of short directed frames, then random
// frames of every opcode but close and of every length encoding, masked and unmasked, and ends
// with a close frame plus trailing bytes that must be swallowed. The sender
// runs in random bursts, the receiver stalls on its own pattern; the checker
// beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_tb;
  import wfd_pkg::*;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef enum int unsigned {LF_SHORT, LF_EXT16, LF_EXT64} len_form_e;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [ByteW-1:0]  s_data  = '0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [ByteW-1:0]  m_data;
  logic [2:0]        m_user;
  logic              m_last;

  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       burst_left = 0;
  int unsigned       beats_sent = 0;

  logic [15:0]       stall_pat  = 16'hFFFF;
  logic [1:0]        stall_mode = '0;
  logic [5:0]        stall_tick = '0;

  websocket_frame_decoder DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  websocket_frame_decoder_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tuser_i   (m_user),
    .m_axis_tlast_i   (m_last),
    .mismatch_count_o (mismatches),
    .pending_count_o  (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: new stall mode and pattern whenever the stall tick counter wraps
  always @(posedge clk) begin
    stall_tick = stall_tick + 6'd1;
    if (stall_tick == '0) begin
      stall_mode = 2'($urandom_range(0, 3));
      stall_pat  = 16'($urandom);
    end
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    case (stall_mode)
      2'd0:    m_ready <= 1'b1;
      2'd1:    m_ready <= 1'($urandom);
      2'd2:    m_ready <= stall_pat[0];
      default: m_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    #3_000_000;
    $display("websocket_frame_decoder regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk); while (!s_ready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // fill < 0: random payload, else every payload byte is fill
  task automatic send_frame(input logic [ByteW-1:0] hdr, input logic masked,
                            input int unsigned len, input len_form_e form,
                            input int fill);
    logic [LenW-1:0] len64;
    len64 = LenW'(len);
    send_byte(hdr);
    case (form)
      LF_SHORT: begin
        send_byte({masked, 7'(len)});
      end
      LF_EXT16: begin
        send_byte({masked, LEN_CODE_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
      end
    endcase
    if (masked) repeat (4) send_byte(ByteW'($urandom));
    repeat (len) send_byte((fill < 0) ? ByteW'($urandom) : ByteW'(fill));
  endtask

  initial begin : stimulus
    logic [3:0]  op;
    logic        masked;
    int unsigned len;
    int unsigned pick;
    int unsigned start;
    len_form_e   form;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    send_frame(8'h81, 1'b0, 0, LF_SHORT, -1);     // empty text
    send_frame(8'h09, 1'b0, 1, LF_SHORT, 8'hFF);  // ping, FIN clear
    send_frame(8'h81, 1'b1, 1, LF_SHORT, 8'h00);  // masked text
    send_frame(8'hFF, 1'b1, 0, LF_EXT16, -1);     // reserved op, 16-bit zero length
    send_frame(8'h82, 1'b0, 1, LF_SHORT, 8'h55);  // binary, dropped
    wait_drained();

    start = beats_sent;
    while (beats_sent < start + 500) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        op = OP_TEXT;
      end else if (pick < 65) begin
        op = OP_PING;
      end else if (pick < 75) begin
        op = OP_BINARY;
      end else if (pick < 82) begin
        op = OP_CONT;
      end else if (pick < 88) begin
        op = OP_PONG;
      end else begin
        do op = 4'($urandom); while (op == OP_CLOSE);
      end

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = 0;
      end else if (pick < 85) begin
        len = $urandom_range(1, 8);
      end else if (pick < 98) begin
        len = $urandom_range(9, 125);
      end else begin
        len = $urandom_range(126, 300);
      end

      if (len > 125) begin
        form = ($urandom_range(0, 1) == 0) ? LF_EXT16 : LF_EXT64;
      end else begin
        pick = $urandom_range(0, 99);
        form = (pick < 80) ? LF_SHORT : ((pick < 92) ? LF_EXT16 : LF_EXT64);
      end
      masked = ($urandom_range(0, 9) < 7);

      send_frame({4'($urandom), op}, masked, len, form, -1);
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    // close, then bytes that must be swallowed
    send_frame({4'($urandom), OP_CLOSE}, 1'($urandom), $urandom_range(0, 5),
               len_form_e'($urandom_range(0, 2)), -1);
    send_byte({4'h8, OP_TEXT});
    send_byte(8'h00);
    repeat (22) send_byte(ByteW'($urandom));

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("websocket_frame_decoder regression: pass");
    end else begin
      $display("websocket_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
